/* src/ial_pkg.sv */
package ial_pkg;

  // Default sizing
  localparam int DEF_CAPACITY  = 64;
  localparam int DEF_WORD_BITS = 32;

  // Fixed field widths on the ports
  localparam int FUNC_W   = 3;
  localparam int INDEX_W  = 6;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 6;
  localparam int DATA_W   = 32;
  localparam int LEN_W    = 7;

  // Operation codes
  localparam logic [FUNC_W-1:0] FN_PUSH   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_INSERT = 3'd1;
  localparam logic [FUNC_W-1:0] FN_DELETE = 3'd2;
  localparam logic [FUNC_W-1:0] FN_FIND   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_READ   = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic load;       // latch the accepted request
    logic check;      // latch the decoded status
    logic start;      // set up the walk over the entries
    logic walk_step;  // advance the walk by one entry
    logic apply;      // final write and length update
    logic reply;      // move the result into the output register
  } ial_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic err;        // request fails with range or full status
    logic push;       // push that fits
    logic walk;       // request needs a walk over the entries
    logic walk_done;  // all reads issued and retired
    logic hit;        // find matched an entry this cycle
    logic out_free;   // output register can take a result
  } ial_stat_t;

endpackage

/* src/ial_ctrl.sv */
module ial_ctrl import ial_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  ial_stat_t st,
  output ial_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_WALK  = 5'b00100,
    S_APPLY = 5'b01000,
    S_REPLY = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        priority if (st.err) begin
          state_nxt = S_REPLY;
        end else if (st.push) begin
          state_nxt = S_APPLY;
        end else if (st.walk) begin
          cmd.start = 1'b1;
          state_nxt = S_WALK;
        end else begin
          state_nxt = S_REPLY;
        end
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (st.hit || st.walk_done) state_nxt = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = S_REPLY;
      end
      S_REPLY: begin
        if (st.out_free) begin
          cmd.reply = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

/* src/ial_datapath.sv */
module ial_datapath import ial_pkg::*; #(
  parameter int CAPACITY  = DEF_CAPACITY,
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic [INDEX_W-1:0]  in_index,
  input  logic [VALUE_W-1:0]  in_value,
  input  ial_cmd_t            cmd,
  output ial_stat_t           st,
  input  logic                out_tready,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic                out_found,
  output logic [POS_W-1:0]    out_position,
  output logic [DATA_W-1:0]   out_data,
  output logic [LEN_W-1:0]    out_length
);

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  logic [WORD_BITS-1:0] mem [CAPACITY];

  logic [FUNC_W-1:0]    func_r;
  logic [CMP_W-1:0]     idx_r;
  logic [WORD_BITS-1:0] val_r;
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     rem_r;
  logic [ADDR_W-1:0]    rd_addr_r;
  logic                 pend_r;
  logic [ADDR_W-1:0]    pend_addr_r;
  logic [WORD_BITS-1:0] rd_data_r;
  logic [STATUS_W-1:0]  res_status_r;
  logic                 res_found_r;
  logic [ADDR_W-1:0]    res_pos_r;
  logic [WORD_BITS-1:0] res_data_r;
  logic                 out_valid_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic                 out_found_r;
  logic [POS_W-1:0]     out_pos_r;
  logic [DATA_W-1:0]    out_data_r;
  logic [LEN_W-1:0]     out_len_r;

  logic [CMP_W+INDEX_W-1:0]     idx_ext;
  logic [CMP_W+CNT_W-1:0]       cnt_ext;
  logic [WORD_BITS+VALUE_W-1:0] val_ext;
  logic [POS_W+ADDR_W-1:0]      pos_ext;
  logic [DATA_W+WORD_BITS-1:0]  data_ext;
  logic [LEN_W+CNT_W-1:0]       len_ext;
  logic [CMP_W-1:0]             cnt_cmp;
  logic [CMP_W-1:0]             ins_rem;
  logic [CMP_W-1:0]             del_rem;
  logic [CMP_W-1:0]             idx_p1;
  logic [CNT_W-1:0]             cnt_m1;
  logic [ADDR_W-1:0]            idx_addr;
  logic is_push, is_ins, is_del, is_find, is_rd;
  logic range_hit, full, range_err, full_err;
  logic hit, issue;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [CNT_W-1:0]     rem_nxt;
  logic [ADDR_W-1:0]    rd_addr_nxt;

  assign idx_ext  = {{CMP_W{1'b0}}, in_index};
  assign cnt_ext  = {{CMP_W{1'b0}}, count_r};
  assign val_ext  = {{WORD_BITS{1'b0}}, in_value};
  assign pos_ext  = {{POS_W{1'b0}}, res_pos_r};
  assign data_ext = {{DATA_W{1'b0}}, res_data_r};
  assign len_ext  = {{LEN_W{1'b0}}, count_r};
  assign cnt_cmp  = cnt_ext[CMP_W-1:0];
  assign ins_rem  = cnt_cmp - idx_r;
  assign del_rem  = cnt_cmp - idx_r - 1'b1;
  assign idx_p1   = idx_r + 1'b1;
  assign cnt_m1   = count_r - 1'b1;
  assign idx_addr = idx_r[ADDR_W-1:0];

  assign is_push = (func_r == FN_PUSH);
  assign is_ins  = (func_r == FN_INSERT);
  assign is_del  = (func_r == FN_DELETE);
  assign is_find = (func_r == FN_FIND);
  assign is_rd   = (func_r == FN_READ);

  assign range_hit = (idx_r >= cnt_cmp);
  assign full      = (count_r == CNT_W'(CAPACITY));
  assign range_err = (is_ins || is_del || is_rd) && range_hit;
  assign full_err  = (is_push || (is_ins && !range_hit)) && full;

  assign hit   = pend_r && is_find && (rd_data_r == val_r);
  assign issue = cmd.walk_step && (rem_r != '0) && !hit;

  assign st.err       = range_err || full_err;
  assign st.push      = is_push && !full;
  assign st.walk      = (is_ins && !range_hit && !full) || ((is_del || is_rd) && !range_hit)
                        || is_find;
  assign st.walk_done = (rem_r == '0) && !pend_r;
  assign st.hit       = hit;
  assign st.out_free  = !out_valid_r || out_tready;

  // Insert walks down from the top, everything else walks up.
  always_comb begin
    rem_nxt     = rem_r;
    rd_addr_nxt = rd_addr_r;
    if (cmd.start) begin
      priority if (is_ins) begin
        rem_nxt     = ins_rem[CNT_W-1:0];
        rd_addr_nxt = cnt_m1[ADDR_W-1:0];
      end else if (is_del) begin
        rem_nxt     = del_rem[CNT_W-1:0];
        rd_addr_nxt = idx_p1[ADDR_W-1:0];
      end else if (is_find) begin
        rem_nxt     = count_r;
        rd_addr_nxt = '0;
      end else begin
        rem_nxt     = CNT_W'(1);
        rd_addr_nxt = idx_addr;
      end
    end else if (issue) begin
      rem_nxt     = rem_r - 1'b1;
      rd_addr_nxt = is_ins ? rd_addr_r - 1'b1 : rd_addr_r + 1'b1;
    end
  end

  // One write port: shifted words during the walk, the new word at apply.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pend_addr_r;
    mem_wdata = rd_data_r;
    if (cmd.walk_step && pend_r && (is_ins || is_del)) begin
      mem_we    = 1'b1;
      mem_waddr = is_ins ? pend_addr_r + 1'b1 : pend_addr_r - 1'b1;
    end else if (cmd.apply && (is_push || is_ins)) begin
      mem_we    = 1'b1;
      mem_waddr = is_push ? count_r[ADDR_W-1:0] : idx_addr;
      mem_wdata = val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (issue)  rd_data_r <= mem[rd_addr_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r      <= in_func;
      idx_r       <= idx_ext[CMP_W-1:0];
      val_r       <= val_ext[WORD_BITS-1:0];
      res_found_r <= 1'b0;
      res_pos_r   <= '0;
      res_data_r  <= '0;
    end else if (cmd.walk_step && pend_r) begin
      if (hit) begin
        res_found_r <= 1'b1;
        res_pos_r   <= pend_addr_r;
      end
      if (is_rd) res_data_r <= rd_data_r;
    end
    if (cmd.check) begin
      res_status_r <= range_err ? ST_RANGE : (full_err ? ST_FULL : ST_OK);
    end
    rem_r     <= rem_nxt;
    rd_addr_r <= rd_addr_nxt;
    if (issue) pend_addr_r <= rd_addr_r;
    if (cmd.reply) begin
      out_status_r <= res_status_r;
      out_found_r  <= res_found_r;
      out_pos_r    <= pos_ext[POS_W-1:0];
      out_data_r   <= data_ext[DATA_W-1:0];
      out_len_r    <= len_ext[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r <= issue;
      if (cmd.apply) begin
        if (is_push || is_ins) count_r <= count_r + 1'b1;
        else if (is_del)       count_r <= count_r - 1'b1;
      end
      if (cmd.reply)       out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_found    = out_found_r;
  assign out_position = out_pos_r;
  assign out_data     = out_data_r;
  assign out_length   = out_len_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("length above capacity");

  a_no_write_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> !cmd.load)
    else $error("memory write while a new request is latched");

  a_count_only_apply: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.apply |=> $stable(count_r))
    else $error("length changed outside apply");

  a_hit_only_find: assert property (@(posedge clk) disable iff (!rst_n)
    hit |-> (func_r == FN_FIND))
    else $error("match flagged outside find");

  a_reply_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.reply |=> out_valid_r)
    else $error("reply did not raise output valid");

endmodule

/* src/indexed_array_list.sv */
// Fixed-capacity word list with a length count. Each request on the input stream
// is push, insert at index, delete at index, find value or read at index, and
// each gives exactly one result carrying status (ok, index out of range, list
// full), found, position, data and the length after the operation. Entries live
// in a single-port-write, registered-read memory; insert and delete move the
// later entries one per cycle, and find scans from position 0 one entry per
// cycle, so the cost follows the walk through that memory. Errors and unused
// codes skip the walk and the write, push writes without a walk, and find
// stops at its first match. One request is in flight at a time; the next
// request is accepted while the previous result still waits in the output
// register.
// Memory contents are undefined after reset and need no clearing: only entries
// below the length are ever read.
module indexed_array_list import ial_pkg::*; #(
  parameter int CAPACITY  = DEF_CAPACITY,
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  // Request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [5:0] index, [37:6] value, [39:38] zero
  input  logic [2:0]  in_tuser,   // [2:0] func
  // Result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [0] found, [6:1] position, [38:7] data,
                                  // [45:39] length, [47:46] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  ial_cmd_t  cmd;
  ial_stat_t st;

  logic [STATUS_W-1:0] res_status;
  logic                res_found;
  logic [POS_W-1:0]    res_position;
  logic [DATA_W-1:0]   res_data;
  logic [LEN_W-1:0]    res_length;

  // Sequence each request: decode, walk, apply, reply.
  ial_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  // Entry memory, length count, walk pointers and the output register.
  ial_datapath #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_func      (in_tuser[FUNC_W-1:0]),
    .in_index     (in_tdata[INDEX_W-1:0]),
    .in_value     (in_tdata[INDEX_W+VALUE_W-1:INDEX_W]),
    .cmd          (cmd),
    .st           (st),
    .out_tready   (out_tready),
    .out_valid    (out_tvalid),
    .out_status   (res_status),
    .out_found    (res_found),
    .out_position (res_position),
    .out_data     (res_data),
    .out_length   (res_length)
  );

  // Pack the result fields, lowest field first, zero pad to whole bytes.
  assign out_tdata = {2'b00, res_length, res_data, res_position, res_found};
  assign out_tuser = res_status;

endmodule

/* tb/indexed_array_list_tb.sv */
module indexed_array_list_tb;
  import ial_pkg::*;

  localparam int LIST_CAP    = DEF_CAPACITY;
  localparam int RANDOM_REQS = 500;
  localparam int HOLD_AT     = 150;     // accepted requests before the long receiver hold-off
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 100;     // outlasts the longest walk
  localparam int CYCLE_LIMIT = 200000;

  // Codes the block treats as no operation
  localparam logic [FUNC_W-1:0] FN_SPARE_LO  = 3'd5;
  localparam logic [FUNC_W-1:0] FN_SPARE_MID = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_HI  = 3'd7;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [INDEX_W-1:0] index;
    logic [VALUE_W-1:0] value;
  } list_request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [POS_W-1:0]    position;
    logic [DATA_W-1:0]   data;
    logic [LEN_W-1:0]    length;
  } list_reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // [5:0] index, [37:6] value, [39:38] zero
  logic [2:0]  in_tuser = '0;   // [2:0] func
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;       // [0] found, [6:1] position, [38:7] data, [45:39] length
  logic [1:0]  out_tuser;       // [1:0] status

  indexed_array_list uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Requests waiting to be offered, and replies predicted for accepted requests
  list_request_t pending_requests[$];
  list_reply_t   expected_replies[$];

  // Shadow copy of the list, advanced once per accepted request
  logic [VALUE_W-1:0] list_words [LIST_CAP];
  int                 list_len = 0;

  // Length as the generator sees it; only the length decides which requests are legal
  int                 gen_len = 0;
  logic [VALUE_W-1:0] value_pool [8];

  int  accepted_count = 0;
  int  errors = 0;
  int  cycle_count = 0;
  bit  hold_off = 1'b0;
  int  hold_left = 0;
  bit  hold_used = 1'b0;

  list_request_t offered;
  int            drv_wait = 0;
  int            drv_calm = 0;
  int            rcv_wait = 0;
  int            rcv_calm = 0;

  // Predict the reply to one request and update the shadow list.
  function automatic list_reply_t apply_request(list_request_t rq);
    list_reply_t r;
    r = '0;
    case (rq.func)
      FN_PUSH: begin
        if (list_len >= LIST_CAP) begin
          r.status = ST_FULL;
        end else begin
          list_words[list_len] = rq.value;
          list_len++;
        end
      end
      FN_INSERT: begin
        // the range test wins over the full test
        if (int'(rq.index) >= list_len) begin
          r.status = ST_RANGE;
        end else if (list_len >= LIST_CAP) begin
          r.status = ST_FULL;
        end else begin
          for (int j = list_len; j > int'(rq.index); j--) list_words[j] = list_words[j-1];
          list_words[rq.index] = rq.value;
          list_len++;
        end
      end
      FN_DELETE: begin
        if (int'(rq.index) >= list_len) begin
          r.status = ST_RANGE;
        end else begin
          for (int j = int'(rq.index); j + 1 < list_len; j++) list_words[j] = list_words[j+1];
          list_len--;
        end
      end
      FN_FIND: begin
        // first match below the length; no match leaves found and position at zero
        for (int j = 0; j < list_len && !r.found; j++) begin
          if (list_words[j] == rq.value) begin
            r.found    = 1'b1;
            r.position = POS_W'(j);
          end
        end
      end
      FN_READ: begin
        if (int'(rq.index) >= list_len) r.status = ST_RANGE;
        else r.data = list_words[rq.index];
      end
      default: ;
    endcase
    r.length = LEN_W'(list_len);
    return r;
  endfunction

  // Queue one request and track the length it leaves behind.
  task automatic queue_request(logic [FUNC_W-1:0] func, logic [INDEX_W-1:0] index,
                               logic [VALUE_W-1:0] value);
    pending_requests.push_back('{func: func, index: index, value: value});
    case (func)
      FN_PUSH:   if (gen_len < LIST_CAP) gen_len++;
      FN_INSERT: if (int'(index) < gen_len && gen_len < LIST_CAP) gen_len++;
      FN_DELETE: if (int'(index) < gen_len) gen_len--;
      default: ;
    endcase
  endtask

  // Mostly a valid position, sometimes any position at all.
  function automatic logic [INDEX_W-1:0] pick_index();
    if (gen_len == 0 || $urandom_range(0, 9) == 0) return INDEX_W'($urandom_range(0, 63));
    return INDEX_W'($urandom_range(0, gen_len - 1));
  endfunction

  // Draw words from a small pool often enough that finds hit.
  function automatic logic [VALUE_W-1:0] pick_value();
    if ($urandom_range(0, 2) == 0) return $urandom();
    return value_pool[$urandom_range(0, 7)];
  endfunction

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Driver: offer queued requests, hold each until accepted, then idle a drawn
  // number of cycles. Predict the reply at the accepting edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= '0;
      drv_wait  = $urandom_range(0, 10);
    end else begin
      if (in_tvalid && in_tready) begin
        expected_replies.push_back(apply_request(offered));
        accepted_count <= accepted_count + 1;
        if (drv_calm > 0) begin
          drv_calm--;
          drv_wait = 0;
        end else begin
          drv_wait = $urandom_range(0, 10);
          if ($urandom_range(0, 19) == 0) drv_calm = $urandom_range(10, 40);
        end
      end
      if (in_tvalid && !in_tready) begin
        // hold the request until the block takes it
      end else if (drv_wait > 0) begin
        drv_wait--;
        in_tvalid <= 1'b0;
      end else if (pending_requests.size() != 0) begin
        offered = pending_requests.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {2'b00, offered.value, offered.index};
        in_tuser  <= offered.func;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off: once enough requests went through, drop ready for
  // a fixed stretch while the driver keeps offering, so the block backs up.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_off <= 1'b0;
    end else if (!hold_used && accepted_count >= HOLD_AT) begin
      hold_off <= 1'b1;
      hold_left = HOLD_CYCLES;
      hold_used = 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      if (hold_left == 0) hold_off <= 1'b0;
    end
  end

  // Monitor: take results, compare against the oldest prediction, then stall
  // a drawn number of cycles before taking the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rcv_wait   = $urandom_range(0, 10);
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_replies.size() == 0) begin
          $display("%0t: result with no request outstanding: status %0h, tdata %0h",
                   $time, out_tuser, out_tdata);
          errors++;
        end else begin
          list_reply_t want;
          want = expected_replies.pop_front();
          compare_field("status",   32'(want.status),   32'(out_tuser));
          compare_field("found",    32'(want.found),    32'(out_tdata[0]));
          compare_field("position", 32'(want.position), 32'(out_tdata[6:1]));
          compare_field("data",     32'(want.data),     out_tdata[38:7]);
          compare_field("length",   32'(want.length),   32'(out_tdata[45:39]));
        end
        if (rcv_calm > 0) begin
          rcv_calm--;
          rcv_wait = 0;
        end else begin
          rcv_wait = $urandom_range(0, 10);
          if ($urandom_range(0, 19) == 0) rcv_calm = $urandom_range(10, 40);
        end
      end
      if (hold_off) begin
        out_tready <= 1'b0;
      end else if (rcv_wait > 0) begin
        rcv_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d replies outstanding", $time, expected_replies.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int total_requests;
    int random_count;
    int roll;
    int extreme_hits;
    bit filling;

    for (int i = 0; i < 8; i++) value_pool[i] = $urandom();
    value_pool[0] = '0;
    value_pool[1] = '1;

    // Directed: empty list, both value extremes, first and last positions,
    // positions at and past the length, find with and without a match,
    // and the unused operation codes.
    queue_request(FN_READ,   6'd0,  32'h0);
    queue_request(FN_DELETE, 6'd0,  32'h0);
    queue_request(FN_INSERT, 6'd0,  32'h1111_1111);
    queue_request(FN_FIND,   6'd0,  32'h0);
    queue_request(FN_PUSH,   6'd63, 32'h0);
    queue_request(FN_PUSH,   6'd0,  32'hFFFF_FFFF);
    queue_request(FN_PUSH,   6'd0,  32'h0);
    queue_request(FN_INSERT, 6'd0,  32'hA5A5_A5A5);
    queue_request(FN_INSERT, 6'd3,  32'h5A5A_5A5A);
    queue_request(FN_FIND,   6'd63, 32'h0);
    queue_request(FN_FIND,   6'd0,  32'hFFFF_FFFF);
    queue_request(FN_FIND,   6'd0,  32'h1234_5678);
    queue_request(FN_READ,   6'd0,  32'h0);
    queue_request(FN_READ,   6'd4,  32'hFFFF_FFFF);
    queue_request(FN_READ,   6'd5,  32'h0);
    queue_request(FN_READ,   6'd63, 32'h0);
    queue_request(FN_INSERT, 6'd63, 32'hFFFF_FFFF);
    queue_request(FN_DELETE, 6'd4,  32'h0);
    queue_request(FN_DELETE, 6'd0,  32'h0);
    queue_request(FN_DELETE, 6'd63, 32'h0);
    queue_request(FN_SPARE_LO,  6'd63, 32'hFFFF_FFFF);
    queue_request(FN_SPARE_MID, 6'd0,  32'h0);
    queue_request(FN_SPARE_HI,  6'd63, 32'hFFFF_FFFF);
    queue_request(FN_READ,   6'd2,  32'h0);

    // Random: alternate fill and drain phases so the list swings between
    // empty and full; linger a few requests at each end, mix in noise.
    random_count = 0;
    extreme_hits = 0;
    filling = 1'b1;
    while (random_count < RANDOM_REQS) begin
      roll = $urandom_range(0, 99);
      if (filling && roll < 55) begin
        queue_request(FN_PUSH, INDEX_W'($urandom_range(0, 63)), pick_value());
      end else if (filling && roll < 80) begin
        queue_request(FN_INSERT, pick_index(), pick_value());
      end else if (!filling && roll < 70) begin
        queue_request(FN_DELETE, pick_index(), pick_value());
      end else if (roll < 88) begin
        queue_request(FN_FIND, pick_index(), pick_value());
      end else if (roll < 95) begin
        queue_request(FN_READ, pick_index(), pick_value());
      end else begin
        queue_request(FUNC_W'($urandom_range(0, 7)), INDEX_W'($urandom_range(0, 63)),
                      $urandom());
      end
      random_count++;
      if ((filling && gen_len == LIST_CAP) || (!filling && gen_len == 0)) extreme_hits++;
      if (extreme_hits >= 5) begin
        filling = !filling;
        extreme_hits = 0;
      end
    end
    total_requests = pending_requests.size();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Sample at the falling edge, clear of the clocked processes.
    while (accepted_count < total_requests || expected_replies.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
src/ial_pkg.sv
src/ial_ctrl.sv
src/ial_datapath.sv
src/indexed_array_list.sv
tb/indexed_array_list_tb.sv
